// ===== src/adc_scan_lowpass_cliff_detect_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the converter scan filter block
// Implication checks on the rising clock edge, held off during reset.
// ---------------------------------------------------------------------------
`ifndef ADC_SCAN_LOWPASS_CLIFF_DETECT_ASSERT_SVH
`define ADC_SCAN_LOWPASS_CLIFF_DETECT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define ASLCD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aslcd: same-cycle check failed");

// Next-cycle implication
`define ASLCD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aslcd: next-cycle check failed");

`else

`define ASLCD_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define ASLCD_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/aslcd_pkg.sv =====
// ---------------------------------------------------------------------------
// aslcd_pkg
// Shared types and fixed constants of the converter scan filter block.
// ---------------------------------------------------------------------------
package aslcd_pkg;

    // Fixed-point formats
    localparam int STATE_FRAC = 16;
    localparam int OUT_FRAC   = 8;
    localparam int RANGE_W    = 21;
    localparam int ZERO_W     = 12;
    localparam int NUM_CLIFF  = 4;
    localparam int NUM_FILT   = 7;

    // Configuration port
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_VOLT_COEF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_COEF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_COEF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIFF_COEF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLIFF_ZERO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLIFF_THR  = 3'd5;

    // Item kinds
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // Scan channel map
    localparam int CH_VOLT   = 0;
    localparam int CH_CLIFF0 = 2;
    localparam int CH_HEAT   = 6;
    localparam int CH_AMP    = 7;

    // Filter lane control
    typedef struct packed {
        logic update;
        logic seed;
    } t_lane_ctrl;

endpackage

// ===== src/aslcd_iir.sv =====
// ---------------------------------------------------------------------------
// aslcd_iir
// One single-pole low-pass lane: y' = (a*y + (1-a)*x + half) >> F, with its
// own state register and seeding from the input on the first update.
// ---------------------------------------------------------------------------
module aslcd_iir
    import aslcd_pkg::*;
#(
    parameter int SAMPLE_BITS    = 10,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  t_lane_ctrl                          i_ctrl,
    input  logic [COEF_FRAC_BITS:0]             i_coef,
    input  logic [SAMPLE_BITS-1:0]              i_x,
    output logic [SAMPLE_BITS+STATE_FRAC-1:0]   o_y_next
);

    localparam int COEF_W  = COEF_FRAC_BITS + 1;
    localparam int STATE_W = SAMPLE_BITS + STATE_FRAC;
    localparam int PROD_W  = COEF_W + STATE_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(1) << COEF_FRAC_BITS;
    localparam logic [ACC_W-1:0]  ACC_HALF  = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    logic [STATE_W-1:0]             r_y;
    logic [STATE_W-1:0]             w_x_ext;
    logic [STATE_W-1:0]             w_y_cur;
    logic [COEF_W-1:0]              w_b;
    logic [PROD_W-1:0]              w_p_state;
    logic [COEF_W+SAMPLE_BITS-1:0]  w_p_input;
    logic [ACC_W-1:0]               w_acc;

    // Use the input as state on the seeding update
    assign w_x_ext = {i_x, {STATE_FRAC{1'b0}}};
    assign w_y_cur = i_ctrl.seed ? w_x_ext : r_y;
    assign w_b     = COEF_ONE - i_coef;

    // Weighted sum with half-up rounding
    assign w_p_state = i_coef * w_y_cur;
    assign w_p_input = w_b * i_x;
    assign w_acc     = ACC_W'(w_p_state)
                     + ACC_W'({w_p_input, {STATE_FRAC{1'b0}}})
                     + ACC_HALF;
    assign o_y_next  = w_acc[COEF_FRAC_BITS +: STATE_W];

    // Advance the state on each filter update
    always_ff @(posedge i_clk) begin
        if (i_ctrl.update) begin
            r_y <= o_y_next;
        end
    end

endmodule

// ===== src/adc_scan_lowpass_cliff_detect.sv =====
// A request is registered in the input register on acceptance, and a tick's
// result is then loaded into the result register; samples and early ticks give none.
// Throughput: one request per cycle unless a tick waits for the result register;
// the seven filter lanes work in parallel between the input and result registers.
// Reset (synchronous, active low) clears scan progress, seeding, handshake state,
// offsets and threshold, sets coefficients to one; buffer and filter state wait to be written.
// ---------------------------------------------------------------------------
// adc_scan_lowpass_cliff_detect
// Round-robin converter scan buffer feeding seven low-pass filters, with
// cliff range computation and drop-off flags on each tick after the first full scan.
// ---------------------------------------------------------------------------
`include "adc_scan_lowpass_cliff_detect_assert.svh"

module adc_scan_lowpass_cliff_detect
    import aslcd_pkg::*;
#(
    parameter int NUM_CHANNELS   = 8,
    parameter int SAMPLE_BITS    = 10,
    parameter int COEF_FRAC_BITS = 16,
    localparam int IN_TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int FILT_W        = SAMPLE_BITS + OUT_FRAC,
    localparam int OUT_RAW_W     = 3 * FILT_W + NUM_CLIFF * RANGE_W + NUM_CLIFF,
    localparam int OUT_TDATA_W   = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration writes
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // Input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // sample
    input  logic                   i_s_tuser,   // func
    // Result stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // volt_filtered, amp_filtered, heat_filtered, range_zero, range_one,
    // range_two, range_three, dropoff_flags
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    localparam int COEF_W    = COEF_FRAC_BITS + 1;
    localparam int STATE_W   = SAMPLE_BITS + STATE_FRAC;
    localparam int RND_SHIFT = STATE_FRAC - OUT_FRAC;
    localparam int IDX_W     = $clog2(NUM_CHANNELS);
    localparam logic [COEF_W-1:0]  COEF_ONE  = COEF_W'(1) << COEF_FRAC_BITS;
    localparam logic [STATE_W:0]   RND_HALF  = (STATE_W + 1)'(1) << (RND_SHIFT - 1);
    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(NUM_CHANNELS - 1);

    // Configuration registers
    logic [COEF_W-1:0]            r_volt_coef;
    logic [COEF_W-1:0]            r_amp_coef;
    logic [COEF_W-1:0]            r_heat_coef;
    logic [COEF_W-1:0]            r_cliff_coef;
    logic [NUM_CLIFF*ZERO_W-1:0]  r_zeros;
    logic signed [RANGE_W-1:0]    r_thr;
    logic [COEF_W-1:0]            w_cfg_coef;

    // Input register and scan state
    logic                         r_in_valid;
    logic                         r_func;
    logic [SAMPLE_BITS-1:0]       r_sample;
    logic [SAMPLE_BITS-1:0]       r_buf [NUM_CHANNELS];
    logic [IDX_W-1:0]             r_scan_idx;
    logic                         r_scan_done;
    logic                         r_need_seed;

    // Result register
    logic                         r_out_valid;
    logic [OUT_TDATA_W-1:0]       r_out_tdata;

    logic                         w_emit;
    logic                         w_proceed;
    logic                         w_s_acc;
    t_lane_ctrl                   w_lane_ctrl;
    logic [SAMPLE_BITS-1:0]       w_lane_x    [NUM_FILT];
    logic [COEF_W-1:0]            w_lane_coef [NUM_FILT];
    logic [STATE_W-1:0]           w_y_next    [NUM_FILT];
    logic [STATE_W:0]             w_rnd       [NUM_FILT];
    logic [FILT_W-1:0]            w_filt      [NUM_FILT];
    logic signed [RANGE_W-1:0]    w_range     [NUM_CLIFF];
    logic [NUM_CLIFF-1:0]         w_flags;
    logic [OUT_TDATA_W-1:0]       n_out_tdata;

    // Saturate coefficient writes to one (hold)
    assign w_cfg_coef = (i_cfg_data[COEF_W-1:0] > COEF_ONE) ? COEF_ONE
                                                           : i_cfg_data[COEF_W-1:0];

    // Hold configuration; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volt_coef  <= COEF_ONE;
            r_amp_coef   <= COEF_ONE;
            r_heat_coef  <= COEF_ONE;
            r_cliff_coef <= COEF_ONE;
            r_zeros      <= '0;
            r_thr        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_VOLT_COEF:  r_volt_coef  <= w_cfg_coef;
                REG_AMP_COEF:   r_amp_coef   <= w_cfg_coef;
                REG_HEAT_COEF:  r_heat_coef  <= w_cfg_coef;
                REG_CLIFF_COEF: r_cliff_coef <= w_cfg_coef;
                REG_CLIFF_ZERO: r_zeros      <= i_cfg_data[NUM_CLIFF*ZERO_W-1:0];
                REG_CLIFF_THR:  r_thr        <= i_cfg_data[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: a tick with a result waits for a free result register
    assign w_emit     = r_in_valid && (r_func == FUNC_TICK) && r_scan_done;
    assign w_proceed  = r_in_valid && (!w_emit || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_proceed;
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_proceed) begin
            r_in_valid <= 1'b0;
        end
    end

    // Capture the request payload
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_func   <= i_s_tuser;
            r_sample <= i_s_tdata[SAMPLE_BITS-1:0];
        end
    end

    // Store samples at the scan index
    always_ff @(posedge i_clk) begin
        if (w_proceed && (r_func == FUNC_SAMPLE)) begin
            r_buf[r_scan_idx] <= r_sample;
        end
    end

    // Advance the scan and track seeding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx  <= '0;
            r_scan_done <= 1'b0;
            r_need_seed <= 1'b1;
        end else if (w_proceed) begin
            if (r_func == FUNC_SAMPLE) begin
                if (r_scan_idx == LAST_IDX) begin
                    r_scan_idx  <= '0;
                    r_scan_done <= 1'b1;
                end else begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
            end else if (w_emit) begin
                r_need_seed <= 1'b0;
            end
        end
    end

    // Route channels and coefficients to the lanes
    always_comb begin
        w_lane_x[0]    = r_buf[CH_VOLT];
        w_lane_x[1]    = r_buf[CH_AMP];
        w_lane_x[2]    = r_buf[CH_HEAT];
        w_lane_coef[0] = r_volt_coef;
        w_lane_coef[1] = r_amp_coef;
        w_lane_coef[2] = r_heat_coef;
        for (int k = 0; k < NUM_CLIFF; k++) begin
            w_lane_x[3+k]    = r_buf[CH_CLIFF0+k];
            w_lane_coef[3+k] = r_cliff_coef;
        end
    end

    assign w_lane_ctrl.update = w_proceed && w_emit;
    assign w_lane_ctrl.seed   = r_need_seed;

    for (genvar g = 0; g < NUM_FILT; g++) begin : g_lane
        aslcd_iir #(
            .SAMPLE_BITS    (SAMPLE_BITS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_iir (
            .i_clk    (i_clk),
            .i_ctrl   (w_lane_ctrl),
            .i_coef   (w_lane_coef[g]),
            .i_x      (w_lane_x[g]),
            .o_y_next (w_y_next[g])
        );
    end

    // Round to output precision, form cliff ranges and flags
    always_comb begin
        for (int i = 0; i < NUM_FILT; i++) begin
            w_rnd[i]  = (STATE_W + 1)'(w_y_next[i]) + RND_HALF;
            w_filt[i] = w_rnd[i][RND_SHIFT +: FILT_W];
        end
        for (int k = 0; k < NUM_CLIFF; k++) begin
            w_range[k] = RANGE_W'(w_filt[3+k])
                       - RANGE_W'({r_zeros[ZERO_W*k +: ZERO_W], {OUT_FRAC{1'b0}}});
            w_flags[k] = (w_range[k] < r_thr);
        end
        n_out_tdata = OUT_TDATA_W'({w_flags, w_range[3], w_range[2], w_range[1],
                                    w_range[0], w_filt[2], w_filt[1], w_filt[0]});
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_lane_ctrl.update) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (w_lane_ctrl.update) begin
            r_out_tdata <= n_out_tdata;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;

    // A stalled request blocks the input side
    `ASLCD_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n,
        r_in_valid && !w_proceed, !o_s_tready)
    // A processed tick after the first scan always presents a result
    `ASLCD_ASSERT_NXT(a_tick_gives_result, i_clk, i_rst_n,
        w_proceed && w_emit, r_out_valid)
    // A tick before the first full scan never raises a result
    `ASLCD_ASSERT_NXT(a_early_tick_silent, i_clk, i_rst_n,
        r_in_valid && (r_func == FUNC_TICK) && !r_scan_done, !$rose(r_out_valid))
    // Seeding is only consumed once the scan is complete
    `ASLCD_ASSERT_IMP(a_seed_after_scan, i_clk, i_rst_n,
        $fell(r_need_seed), r_scan_done)

endmodule

// ===== verif/tb_adc_scan_lowpass_cliff_detect.sv =====
// ---------------------------------------------------------------------------
// tb_adc_scan_lowpass_cliff_detect
// Drives converter samples and filter ticks into the scan filter block over
// the input stream. Idle cycles come at random on both streams. Each
// filtered reading is predicted from a bit-accurate copy of the scan buffer,
// the seven low-pass lanes and the cliff offsets, and checked field by field.
// ---------------------------------------------------------------------------
module tb_adc_scan_lowpass_cliff_detect
    import aslcd_pkg::*;
();

    localparam int NUM_CH           = 8;
    localparam int SMP_W            = 10;
    localparam int COEF_FRAC        = 16;
    localparam int IN_W             = ((SMP_W + 7) / 8) * 8;
    localparam int FILT_W           = SMP_W + OUT_FRAC;
    localparam int OUT_W            =
        ((3 * FILT_W + NUM_CLIFF * RANGE_W + NUM_CLIFF + 7) / 8) * 8;
    localparam int SPAN_LSB         = 3 * FILT_W;
    localparam int FLAG_LSB         = SPAN_LSB + NUM_CLIFF * RANGE_W;
    localparam int COEF_W           = COEF_FRAC + 1;
    localparam int POLE_ONE         = 1 << COEF_FRAC;
    localparam int FIRST_CLIFF_LANE = 3;
    localparam int SETTLE_CYCLES    = 4;
    localparam int STALL_LIMIT      = 2000;
    localparam int IDLE_PCT         = 29;
    localparam int TICK_PCT         = 30;
    localparam int RAND_PHASES      = 12;
    localparam int PHASE_ITEMS      = 119;
    localparam int CALM_PHASE       = 5;

    localparam logic [SMP_W-1:0] SMP_MAX = '1;

    // Indexes past the register list; the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [SMP_W-1:0] CORNER_SMP [NUM_CH] = '{
        10'h000, 10'h3FF, 10'h155, 10'h2AA, 10'h3FF, 10'h000, 10'h200, 10'h001
    };

    typedef struct packed {
        logic [FILT_W-1:0]                   volt;
        logic [FILT_W-1:0]                   amp;
        logic [FILT_W-1:0]                   heat;
        logic [NUM_CLIFF-1:0][RANGE_W-1:0]   span;
        logic [NUM_CLIFF-1:0]                flags;
    } t_reading;

    // Tracks scan buffer, filter lanes and settings; holds pending readings
    class cliff_filter_tracker;
        longint unsigned           pole [4];
        logic [CFG_W-1:0]          zero_offsets;
        logic signed [RANGE_W-1:0] drop_thr;
        logic [SMP_W-1:0]          scan_buf [NUM_CH];
        int unsigned               scan_pos;
        bit                        scan_done;
        bit                        seed_pending;
        longint unsigned           lane_y [NUM_FILT];
        t_reading                  expected_readings [$];
        int unsigned               errors;

        function new();
            foreach (pole[i]) pole[i] = POLE_ONE;
            zero_offsets = '0;
            drop_thr     = '0;
            foreach (scan_buf[i]) scan_buf[i] = '0;
            scan_pos     = 0;
            scan_done    = 1'b0;
            seed_pending = 1'b1;
            foreach (lane_y[i]) lane_y[i] = 0;
            errors       = 0;
        endfunction

        function int lane_chan(int lane);
            if (lane == 0) return CH_VOLT;
            if (lane == 1) return CH_AMP;
            if (lane == 2) return CH_HEAT;
            return CH_CLIFF0 + lane - FIRST_CLIFF_LANE;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            longint unsigned v;
            v = 64'(data[COEF_W-1:0]);
            // saturate poles above one to hold
            if (idx <= REG_CLIFF_COEF)
                pole[idx] = (v > POLE_ONE) ? POLE_ONE : v;
            else if (idx == REG_CLIFF_ZERO)
                zero_offsets = data;
            else if (idx == REG_CLIFF_THR)
                drop_thr = data[RANGE_W-1:0];
        endfunction

        function void note_request(logic func, logic [SMP_W-1:0] smp);
            longint unsigned a, x, acc, z;
            longint unsigned rounded [NUM_FILT];
            longint          d, thr;
            t_reading        r;
            int              p;

            // store sample and advance the scan
            if (func == FUNC_SAMPLE) begin
                scan_buf[scan_pos] = smp;
                scan_pos++;
                if (scan_pos == NUM_CH) begin
                    scan_pos  = 0;
                    scan_done = 1'b1;
                end
                return;
            end
            // drop ticks until the first full scan
            if (!scan_done) return;

            if (seed_pending) begin
                for (int l = 0; l < NUM_FILT; l++)
                    lane_y[l] = 64'(scan_buf[lane_chan(l)]) << STATE_FRAC;
                seed_pending = 1'b0;
            end

            // run every lane: y = a*y + (1-a)*x, round half up
            for (int l = 0; l < NUM_FILT; l++) begin
                p   = (l < FIRST_CLIFF_LANE) ? l : int'(REG_CLIFF_COEF);
                a   = pole[p];
                x   = 64'(scan_buf[lane_chan(l)]) << STATE_FRAC;
                acc = a * lane_y[l] + (POLE_ONE - a) * x + (64'd1 << (COEF_FRAC - 1));
                lane_y[l]  = acc >> COEF_FRAC;
                rounded[l] = (lane_y[l] + (64'd1 << (STATE_FRAC - OUT_FRAC - 1)))
                             >> (STATE_FRAC - OUT_FRAC);
            end

            r.volt = FILT_W'(rounded[0]);
            r.amp  = FILT_W'(rounded[1]);
            r.heat = FILT_W'(rounded[2]);
            thr    = drop_thr;
            for (int k = 0; k < NUM_CLIFF; k++) begin
                z = (zero_offsets >> (ZERO_W * k)) & 64'hFFF;
                d = longint'(rounded[FIRST_CLIFF_LANE + k]) - longint'(z << OUT_FRAC);
                r.span[k]  = RANGE_W'(d);
                r.flags[k] = (d < thr);
            end
            expected_readings.push_back(r);
        endfunction

        function void compare_field(string name, logic [RANGE_W-1:0] want,
                                    logic [RANGE_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_reading(logic [OUT_W-1:0] t);
            t_reading got, want;
            got.volt = t[FILT_W-1:0];
            got.amp  = t[2*FILT_W-1:FILT_W];
            got.heat = t[3*FILT_W-1:2*FILT_W];
            for (int k = 0; k < NUM_CLIFF; k++)
                got.span[k] = t[SPAN_LSB + k * RANGE_W +: RANGE_W];
            got.flags = t[FLAG_LSB +: NUM_CLIFF];

            if (expected_readings.size() == 0) begin
                errors++;
                $display("%0t: unexpected reading: expected none, got %h", $time, t);
                return;
            end
            want = expected_readings.pop_front();
            compare_field("volt_filtered", RANGE_W'(want.volt), RANGE_W'(got.volt));
            compare_field("amp_filtered", RANGE_W'(want.amp), RANGE_W'(got.amp));
            compare_field("heat_filtered", RANGE_W'(want.heat), RANGE_W'(got.heat));
            for (int k = 0; k < NUM_CLIFF; k++)
                compare_field($sformatf("range_%0d", k), want.span[k], got.span[k]);
            compare_field("dropoff_flags", RANGE_W'(want.flags), RANGE_W'(got.flags));
        endfunction
    endclass

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;

    bit                   calm = 1'b0;
    int unsigned          quiet_cycles = 0;
    cliff_filter_tracker  tracker;

    adc_scan_lowpass_cliff_detect dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Accept readings with random stalls and check each one
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_reading(m_tdata);
        m_tready <= rst_n && (calm || $urandom_range(99) >= IDLE_PCT);
    end

    // End the run if nothing moves for too long
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Leave the write enable high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        tracker.note_config(idx, val);
    endtask

    // Offer one request after an optional idle gap; hold valid on return
    task automatic send_req(input logic func, input logic [SMP_W-1:0] smp);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= IN_W'(smp);
        do @(posedge clk); while (!s_tready);
        tracker.note_request(func, smp);
    endtask

    // Drain all pending readings, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (tracker.expected_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_pole();
        case ($urandom_range(5))
            0:       return '0;
            1:       return CFG_W'(POLE_ONE);
            2:       return CFG_W'(POLE_ONE - $urandom_range(1, 2000));
            3:       return CFG_W'($urandom_range(POLE_ONE + 1, 2 * POLE_ONE - 1));
            default: return CFG_W'($urandom_range(0, POLE_ONE));
        endcase
    endfunction

    task automatic shuffle_config();
        logic [CFG_W-1:0]   zeros;
        logic [RANGE_W-1:0] thr;
        for (int k = 0; k < NUM_CLIFF; k++)
            zeros[k * ZERO_W +: ZERO_W] =
                $urandom_range(1) ? ZERO_W'($urandom_range(1023)) : ZERO_W'($urandom);
        // mostly keep the threshold near the typical cliff ranges
        if ($urandom_range(3) == 0)
            thr = RANGE_W'($urandom);
        else
            thr = RANGE_W'($urandom_range(524287) - 262144);
        write_reg(REG_VOLT_COEF, pick_pole());
        write_reg(REG_AMP_COEF, pick_pole());
        write_reg(REG_HEAT_COEF, pick_pole());
        write_reg(REG_CLIFF_COEF, pick_pole());
        write_reg(REG_CLIFF_ZERO, zeros);
        write_reg(REG_CLIFF_THR, CFG_W'(thr));
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO,
                      CFG_W'({$urandom, $urandom}));
        cfg_we <= 1'b0;
    endtask

    initial begin
        tracker = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: ticks before the first scan give nothing, then
        // the seed tick with all filters holding
        send_req(FUNC_TICK, SMP_MAX);
        for (int i = 0; i < NUM_CH; i++)
            send_req(FUNC_SAMPLE, CORNER_SMP[i]);
        send_req(FUNC_TICK, '0);
        send_req(FUNC_TICK, SMP_MAX);
        send_req(FUNC_SAMPLE, SMP_MAX);
        send_req(FUNC_SAMPLE, '0);
        send_req(FUNC_SAMPLE, SMP_MAX);
        send_req(FUNC_TICK, '0);
        settle();

        // Pass-through filters, largest offsets, highest threshold
        write_reg(REG_VOLT_COEF, '0);
        write_reg(REG_AMP_COEF, '0);
        write_reg(REG_HEAT_COEF, '0);
        write_reg(REG_CLIFF_COEF, '0);
        write_reg(REG_CLIFF_ZERO, '1);
        write_reg(REG_CLIFF_THR, CFG_W'({1'b0, {(RANGE_W - 1){1'b1}}}));
        cfg_we <= 1'b0;
        send_req(FUNC_SAMPLE, SMP_MAX);
        send_req(FUNC_TICK, '0);
        send_req(FUNC_TICK, SMP_MAX);
        settle();

        // Poles above one saturate to hold; lowest threshold; spare indexes
        write_reg(REG_VOLT_COEF, CFG_W'({COEF_W{1'b1}}));
        write_reg(REG_AMP_COEF, CFG_W'(POLE_ONE - 1));
        write_reg(REG_HEAT_COEF, CFG_W'(1));
        write_reg(REG_CLIFF_COEF, CFG_W'(POLE_ONE / 2));
        write_reg(REG_CLIFF_ZERO, '0);
        write_reg(REG_CLIFF_THR, CFG_W'({1'b1, {(RANGE_W - 1){1'b0}}}));
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        cfg_we <= 1'b0;
        send_req(FUNC_SAMPLE, '0);
        send_req(FUNC_SAMPLE, 10'h001);
        send_req(FUNC_TICK, '0);
        send_req(FUNC_TICK, SMP_MAX);
        send_req(FUNC_TICK, '0);
        settle();

        // Random phases, each under fresh settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            shuffle_config();
            calm = (ph == CALM_PHASE);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(99) < TICK_PCT)
                    send_req(FUNC_TICK, SMP_W'($urandom));
                else if ($urandom_range(9) == 0)
                    send_req(FUNC_SAMPLE, $urandom_range(1) ? SMP_MAX : SMP_W'(0));
                else
                    send_req(FUNC_SAMPLE, SMP_W'($urandom));
            end
            settle();
        end

        if (tracker.errors == 0 && tracker.expected_readings.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
